FILE: design/fxa_pkg.sv
// Package for the Q24.8 fixed-point ALU: word widths, command codes,
// and the word type carried down the divider cell chain. No dependencies.
package fxa_pkg;
  localparam int FRAC_BITS = 8;
  localparam int WORD_BITS = 32;
  localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
  localparam int DIV_CELLS = NUM_BITS;

  typedef enum logic [3:0] {
    CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
    CMD_MIN = 4'd4, CMD_MAX = 4'd5, CMD_FROM_INT = 4'd6, CMD_TO_INT = 4'd7,
    CMD_INC = 4'd8, CMD_DEC = 4'd9, CMD_CMP = 4'd10
  } cmd_t;

  typedef struct packed {
    logic                 vld;
    logic                 is_div;
    logic                 neg;
    logic [WORD_BITS-1:0] res;
    logic                 lt;
    logic                 eq;
    logic                 gt;
    logic                 dz;
    logic [NUM_BITS-1:0]  quo;
    logic [WORD_BITS:0]   rem;
    logic [WORD_BITS-1:0] dvs;
  } fxa_word_t;
endpackage

FILE: design/fxa_cell.sv
// One restoring-division cell: shift in one numerator bit, subtract the
// divisor when it fits, hand the word on. Uses fxa_pkg.
module fxa_cell import fxa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  fxa_word_t in_w,
  output fxa_word_t out_w
);
  fxa_word_t            w_nxt;
  logic [WORD_BITS:0]   trial;
  logic [WORD_BITS+1:0] diff;

  always_comb begin
    w_nxt = in_w;
    trial = {in_w.rem[WORD_BITS-1:0], in_w.quo[NUM_BITS-1]};
    diff  = {1'b0, trial} - {2'b00, in_w.dvs};
    w_nxt.quo = {in_w.quo[NUM_BITS-2:0], ~diff[WORD_BITS+1]};
    w_nxt.rem = diff[WORD_BITS+1] ? trial : diff[WORD_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_w.vld <= 1'b0;
    end else begin
      out_w.vld <= in_w.vld;
    end
    out_w.is_div <= w_nxt.is_div;
    out_w.neg    <= w_nxt.neg;
    out_w.res    <= w_nxt.res;
    out_w.lt     <= w_nxt.lt;
    out_w.eq     <= w_nxt.eq;
    out_w.gt     <= w_nxt.gt;
    out_w.dz     <= w_nxt.dz;
    out_w.quo    <= w_nxt.quo;
    out_w.rem    <= w_nxt.rem;
    out_w.dvs    <= w_nxt.dvs;
  end
endmodule

FILE: design/fixed_point_q24_8_alu_unit.sv
// Top level of the Q24.8 fixed-point ALU: front stage, divider cell chain,
// output stage. Depends on fxa_pkg and fxa_cell.
//
// Usage: drive in_command, in_operand_a, in_operand_b and pulse start.
// busy is tied low, so a word is taken on every cycle start is high and
// one new operation may enter each clock: throughput one word per cycle.
// Every operation, divide or not, runs down the same fixed pipeline so
// results leave in order. An accepted word is loaded into the front
// register, then advances through the DIV_CELLS cells, one per quotient
// bit of the 40-bit scaled numerator, and then into the output register
// that drives out_valid, out_result and the flags.
// out_valid marks each result word with out_result and the flags;
// the receiver cannot stall and must take each word as it appears.
// Multiply is computed in the front stage on 32x32 bits; non-divide
// results simply ride along the chain. Divide by zero gives zero and
// raises out_div_by_zero.
// Synchronous active-low reset drops every word in flight.
module fixed_point_q24_8_alu_unit import fxa_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3:0]                  in_command,
  input  logic signed [WORD_BITS-1:0] in_operand_a,
  input  logic signed [WORD_BITS-1:0] in_operand_b,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_result,
  output logic                        out_is_less,
  output logic                        out_is_equal,
  output logic                        out_is_greater,
  output logic                        out_div_by_zero
);
  fxa_word_t front_nxt;
  fxa_word_t chain [DIV_CELLS+1];
  logic signed [2*WORD_BITS-1:0] prod;
  logic [WORD_BITS-1:0] abs_a, abs_b;
  logic [WORD_BITS-1:0] q_fin;
  logic out_valid_r;
  logic [WORD_BITS-1:0] out_result_r;
  logic out_lt_r, out_eq_r, out_gt_r, out_dz_r;

  assign busy = 1'b0;

  always_comb begin
    prod  = (2*WORD_BITS)'(in_operand_a) * (2*WORD_BITS)'(in_operand_b);
    abs_a = in_operand_a[WORD_BITS-1] ? -in_operand_a : in_operand_a;
    abs_b = in_operand_b[WORD_BITS-1] ? -in_operand_b : in_operand_b;
    front_nxt        = '0;
    front_nxt.vld    = start;
    front_nxt.lt     = in_operand_a < in_operand_b;
    front_nxt.eq     = in_operand_a == in_operand_b;
    front_nxt.gt     = in_operand_a > in_operand_b;
    front_nxt.neg    = in_operand_a[WORD_BITS-1] ^ in_operand_b[WORD_BITS-1];
    front_nxt.quo    = {abs_a, {FRAC_BITS{1'b0}}};
    front_nxt.dvs    = abs_b;
    case (in_command)
      CMD_ADD:      front_nxt.res = in_operand_a + in_operand_b;
      CMD_SUB:      front_nxt.res = in_operand_a - in_operand_b;
      CMD_MUL:      front_nxt.res = prod[FRAC_BITS +: WORD_BITS];
      CMD_DIV: begin
        front_nxt.is_div = (in_operand_b != '0);
        front_nxt.dz     = (in_operand_b == '0);
      end
      CMD_MIN:      front_nxt.res = (in_operand_a <= in_operand_b) ? in_operand_a : in_operand_b;
      CMD_MAX:      front_nxt.res = (in_operand_a >= in_operand_b) ? in_operand_a : in_operand_b;
      CMD_FROM_INT: front_nxt.res = in_operand_a <<< FRAC_BITS;
      CMD_TO_INT:   front_nxt.res = in_operand_a >>> FRAC_BITS;
      CMD_INC:      front_nxt.res = in_operand_a + WORD_BITS'(1);
      CMD_DEC:      front_nxt.res = in_operand_a - WORD_BITS'(1);
      default:      front_nxt.res = '0;
    endcase
  end

  // Front register: hold the decoded word for the first cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].vld <= 1'b0;
    end else begin
      chain[0].vld <= front_nxt.vld;
    end
    chain[0].is_div <= front_nxt.is_div;
    chain[0].neg    <= front_nxt.neg;
    chain[0].res    <= front_nxt.res;
    chain[0].lt     <= front_nxt.lt;
    chain[0].eq     <= front_nxt.eq;
    chain[0].gt     <= front_nxt.gt;
    chain[0].dz     <= front_nxt.dz;
    chain[0].quo    <= front_nxt.quo;
    chain[0].rem    <= front_nxt.rem;
    chain[0].dvs    <= front_nxt.dvs;
  end

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
    fxa_cell u_cell (.clk(clk), .rst_n(rst_n), .in_w(chain[i]), .out_w(chain[i+1]));
  end

  // Apply quotient sign and wrap to the word.
  assign q_fin = chain[DIV_CELLS].neg ? -chain[DIV_CELLS].quo[WORD_BITS-1:0]
                                      : chain[DIV_CELLS].quo[WORD_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[DIV_CELLS].vld;
    end
    out_result_r <= chain[DIV_CELLS].is_div ? q_fin : chain[DIV_CELLS].res;
    out_lt_r     <= chain[DIV_CELLS].lt;
    out_eq_r     <= chain[DIV_CELLS].eq;
    out_gt_r     <= chain[DIV_CELLS].gt;
    out_dz_r     <= chain[DIV_CELLS].dz;
  end

  assign out_valid       = out_valid_r;
  assign out_result      = out_result_r;
  assign out_is_less     = out_lt_r;
  assign out_is_equal    = out_eq_r;
  assign out_is_greater  = out_gt_r;
  assign out_div_by_zero = out_dz_r;

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_is_less, out_is_equal, out_is_greater}))
    else $error("compare flags not one-hot");
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_div_by_zero) |-> (out_result == '0))
    else $error("divide by zero result not zero");
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown({out_result, out_is_less, out_is_equal,
                               out_is_greater, out_div_by_zero}))
    else $error("result word has unknown bits");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    chain[0].vld |-> ##(DIV_CELLS+1) out_valid)
    else $error("word lost in chain");
endmodule

FILE: dv/fixed_point_q24_8_alu_unit_tb.sv
// Self-checking testbench for the Q24.8 fixed-point ALU top level.
// Drives command words from a queue, predicts each result, checks the output strobe.
// Depends on fxa_pkg and the fixed_point_q24_8_alu_unit RTL.
`timescale 1ns / 1ps

module fixed_point_q24_8_alu_unit_tb;
  import fxa_pkg::*;

  typedef struct {
    logic [3:0]  cmd;
    logic [31:0] a;
    logic [31:0] b;
  } alu_word_t;

  typedef struct {
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        dz;
  } alu_result_t;

  localparam int LATENCY   = DIV_CELLS + 2;
  localparam int CYCLE_CAP = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [3:0]  in_command = '0;
  logic signed [31:0] in_operand_a = '0;
  logic signed [31:0] in_operand_b = '0;
  logic        out_valid;
  logic signed [31:0] out_result;
  logic        out_is_less, out_is_equal, out_is_greater, out_div_by_zero;

  alu_word_t   pending_words[$];
  alu_result_t expected_results[$];
  int          errors = 0;
  int          results_seen = 0;
  int          cycles = 0;
  bit          hold_sender = 1'b0;
  bit          no_gaps = 1'b0;
  int          gap_left = 0;

  fixed_point_q24_8_alu_unit dut (
    .clk, .rst_n, .start, .busy, .in_command, .in_operand_a, .in_operand_b,
    .out_valid, .out_result, .out_is_less, .out_is_equal, .out_is_greater,
    .out_div_by_zero
  );

  always #5 clk = ~clk;

  // Compute the expected result word for one command word.
  function automatic alu_result_t alu_predict(alu_word_t w);
    alu_result_t r;
    logic signed [31:0] a, b;
    logic signed [63:0] prod, num, quo;
    a = w.a;
    b = w.b;
    r.res = '0;
    r.dz  = 1'b0;
    r.lt  = a < b;
    r.eq  = a == b;
    r.gt  = a > b;
    case (w.cmd)
      CMD_ADD: r.res = a + b;
      CMD_SUB: r.res = a - b;
      CMD_MUL: begin
        prod  = 64'(a) * 64'(b);
        r.res = 32'(prod >>> FRAC_BITS);
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          // 64-bit signed divide truncates toward zero, as required
          num   = 64'(a) <<< FRAC_BITS;
          quo   = num / 64'(b);
          r.res = 32'(quo);
        end
      end
      CMD_MIN:      r.res = (a <= b) ? a : b;
      CMD_MAX:      r.res = (a >= b) ? a : b;
      CMD_FROM_INT: r.res = a <<< FRAC_BITS;
      CMD_TO_INT:   r.res = a >>> FRAC_BITS;
      CMD_INC:      r.res = a + 1;
      CMD_DEC:      r.res = a - 1;
      default:      r.res = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 3) - 1;
      3: return 32'($signed($urandom_range(0, 8191)) - 4096);
      4: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(logic [3:0] cmd, logic [31:0] a, logic [31:0] b);
    alu_word_t w;
    w.cmd = cmd;
    w.a = a;
    w.b = b;
    pending_words.push_back(w);
  endtask

  // Driver: hold start while the queue has words, insert random gaps.
  always @(posedge clk) begin
    alu_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(alu_predict('{in_command, in_operand_a, in_operand_b}));
      end
      if (start && busy) begin
        // word not taken yet: keep it on the ports
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (hold_sender || pending_words.size() == 0) begin
        start <= 1'b0;
      end else if (!no_gaps && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(0, 6);
        start <= 1'b0;
      end else begin
        w = pending_words.pop_front();
        in_command   <= w.cmd;
        in_operand_a <= w.a;
        in_operand_b <= w.b;
        start <= 1'b1;
      end
    end
  end

  // Monitor: compare each strobed result against the oldest expectation.
  always @(posedge clk) begin
    alu_result_t e;
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", out_result);
        errors = errors + 1;
      end else begin
        e = expected_results.pop_front();
        if (out_result !== e.res) begin
          $error("result: expected %h actual %h", e.res, out_result);
          errors = errors + 1;
        end
        if (out_is_less !== e.lt) begin
          $error("is_less: expected %b actual %b", e.lt, out_is_less);
          errors = errors + 1;
        end
        if (out_is_equal !== e.eq) begin
          $error("is_equal: expected %b actual %b", e.eq, out_is_equal);
          errors = errors + 1;
        end
        if (out_is_greater !== e.gt) begin
          $error("is_greater: expected %b actual %b", e.gt, out_is_greater);
          errors = errors + 1;
        end
        if (out_div_by_zero !== e.dz) begin
          $error("div_by_zero: expected %b actual %b", e.dz, out_div_by_zero);
          errors = errors + 1;
        end
      end
    end
    if (cycles > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycles);
      $display("** fixed_point_q24_8_alu_unit: FAILED **");
      $finish;
    end
  end

  function automatic bit drained();
    return pending_words.size() == 0 && expected_results.size() == 0 && !start;
  endfunction

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100, 32'hffff_ff00};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every command at the field extremes, divide by zero, unused codes.
    for (int c = 0; c <= 10; c++) push_word(4'(c), edges[c % 6], edges[(c + 1) % 6]);
    push_word(CMD_DIV, 32'h7fff_ffff, 32'h0);
    push_word(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    push_word(CMD_DIV, 32'hffff_fe80, 32'h200);
    push_word(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    push_word(CMD_MUL, 32'hffff_ffff, 32'h1);
    push_word(CMD_TO_INT, 32'hffff_ff01, 32'h0);
    push_word(CMD_CMP, 32'h1234, 32'h1234);
    push_word(4'd11, 32'h5, 32'h3);
    push_word(4'd15, 32'hffff_ffff, 32'hffff_ffff);

    // Random: mostly valid commands with mixed operand shapes.
    for (int i = 0; i < 1700; i++) begin
      logic [3:0]  c;
      logic [31:0] a;
      c = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      a = pick_operand();
      push_word(c, a, ($urandom_range(0, 7) == 0) ? a : pick_operand());
      if (i == 800) begin
        // Pause the sender until the pipeline has emptied.
        while (pending_words.size() != 0) @(posedge clk);
        hold_sender = 1'b1;
        while (!drained()) @(posedge clk);
        hold_sender = 1'b0;
      end
      if (i == 1500) begin
        // Run the tail back to back once the earlier words are sent.
        while (pending_words.size() != 0) @(posedge clk);
        no_gaps = 1'b1;
      end
    end

    while (!drained()) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d result words over all 11 commands, unused codes, edges.",
             results_seen);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("** fixed_point_q24_8_alu_unit: PASSED **");
    end else begin
      $display("** fixed_point_q24_8_alu_unit: FAILED **");
    end
    $finish;
  end
endmodule

FILE: files.f
design/fxa_pkg.sv
design/fxa_cell.sv
design/fixed_point_q24_8_alu_unit.sv
dv/fixed_point_q24_8_alu_unit_tb.sv
